/* sv/assert_macros.svh */
// Assertion helpers for the deframer RTL.
// Clocked assertions; IFD_ASSERT uses asynchronous active-low reset as disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define IFD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define IFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ifd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the interleaved frame deframer.
// ----------------------------------------------------------------------------
package ifd_pkg;

	// Framing constants
	localparam logic [7:0] MARKER_BYTE = 8'h24;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_CHANNEL   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 2'd2;

	// Register reset values
	localparam logic [7:0]  MAX_CHANNEL_RST   = 8'd2;
	localparam logic [15:0] MAX_LENGTH_RST    = 16'd1600;
	localparam logic [15:0] ATTEMPT_LIMIT_RST = 16'd10000;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_BAD_MARK = 2'd1,
		KIND_BAD_CHAN = 2'd2,
		KIND_BAD_LEN  = 2'd3
	} kind_t;

	// Parser phases, one-hot
	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_CHAN = 5'b00010,
		PH_LENH = 5'b00100,
		PH_LENL = 5'b01000,
		PH_DATA = 5'b10000
	} phase_t;

	// One classified result as queued between front and back
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [7:0]  chan;
		logic [15:0] frame_len;
		logic        last;
		logic        sync_lost;
	} res_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

/* sv/ifd_front.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ifd_front
// Byte parser: holds the configuration registers, walks the header phases,
// tracks sync attempts and emits one classified result per result byte.
// ----------------------------------------------------------------------------
module ifd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ifd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ifd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic [7:0]                    rx_byte,
	input  logic                          q_full,
	output logic                          in_stall,
	output logic                          push,
	output ifd_pkg::res_t                 push_res
);

	logic [7:0]      max_channel_q;
	logic [15:0]     max_length_q;
	logic [15:0]     attempt_limit_q;
	ifd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      cur_channel_q, cur_channel_d;
	logic [7:0]      len_high_q, len_high_d;
	logic [15:0]     cur_length_q, cur_length_d;
	logic [15:0]     bytes_left_q, bytes_left_d;
	logic [15:0]     attempts_q, attempts_d;

	logic            accept;
	logic [15:0]     att_dec;
	logic [15:0]     len_w;
	logic [15:0]     left_dec;
	logic            res_valid;
	logic            frame_end;
	logic            hunt_now;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign att_dec  = (attempts_q != 16'd0) ? attempts_q - 16'd1 : 16'd0;
	assign len_w    = {len_high_q, rx_byte};
	assign left_dec = bytes_left_q - 16'd1;
	assign push     = accept && res_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_channel_q   <= ifd_pkg::MAX_CHANNEL_RST;
			max_length_q    <= ifd_pkg::MAX_LENGTH_RST;
			attempt_limit_q <= ifd_pkg::ATTEMPT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ifd_pkg::REG_MAX_CHANNEL:   max_channel_q   <= cfg_data[7:0];
				ifd_pkg::REG_MAX_LENGTH:    max_length_q    <= cfg_data;
				ifd_pkg::REG_ATTEMPT_LIMIT: attempt_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Phase decode and result build
	always_comb begin
		phase_d       = phase_q;
		cur_channel_d = cur_channel_q;
		len_high_d    = len_high_q;
		cur_length_d  = cur_length_q;
		bytes_left_d  = bytes_left_q;
		attempts_d    = attempts_q;
		res_valid     = 1'b0;
		push_res      = '{kind: ifd_pkg::KIND_PAYLOAD, data: rx_byte, chan: cur_channel_q,
			frame_len: cur_length_q, last: 1'b0, sync_lost: 1'b0};
		unique case (phase_q)
			ifd_pkg::PH_CHAN: begin
				if (rx_byte > max_channel_q) begin
					res_valid          = 1'b1;
					push_res.kind      = ifd_pkg::KIND_BAD_CHAN;
					push_res.chan      = rx_byte;
					push_res.frame_len = 16'd0;
					push_res.sync_lost = (attempts_q == 16'd0);
					if (attempts_q == 16'd0) attempts_d = attempt_limit_q;
					phase_d = ifd_pkg::PH_HUNT;
				end else begin
					cur_channel_d = rx_byte;
					phase_d       = ifd_pkg::PH_LENH;
				end
			end
			ifd_pkg::PH_LENH: begin
				len_high_d = rx_byte;
				phase_d    = ifd_pkg::PH_LENL;
			end
			ifd_pkg::PH_LENL: begin
				if (len_w == 16'd0 || len_w > max_length_q) begin
					res_valid          = 1'b1;
					push_res.kind      = ifd_pkg::KIND_BAD_LEN;
					push_res.frame_len = len_w;
					push_res.sync_lost = (attempts_q == 16'd0);
					if (attempts_q == 16'd0) attempts_d = attempt_limit_q;
					phase_d = ifd_pkg::PH_HUNT;
				end else begin
					cur_length_d = len_w;
					bytes_left_d = len_w;
					phase_d      = ifd_pkg::PH_DATA;
				end
			end
			ifd_pkg::PH_DATA: begin
				res_valid     = 1'b1;
				bytes_left_d  = left_dec;
				push_res.last = (left_dec == 16'd0);
				if (left_dec == 16'd0) begin
					attempts_d = attempt_limit_q;
					phase_d    = ifd_pkg::PH_HUNT;
				end
			end
			default: begin
				// hunting; stray phase codes land here too
				if (rx_byte != ifd_pkg::MARKER_BYTE) begin
					res_valid          = 1'b1;
					push_res.kind      = ifd_pkg::KIND_BAD_MARK;
					push_res.chan      = 8'd0;
					push_res.frame_len = 16'd0;
					push_res.sync_lost = (att_dec == 16'd0);
					attempts_d = (att_dec == 16'd0) ? attempt_limit_q : att_dec;
					phase_d    = ifd_pkg::PH_HUNT;
				end else begin
					attempts_d = att_dec;
					phase_d    = ifd_pkg::PH_CHAN;
				end
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ifd_pkg::PH_HUNT;
			cur_channel_q <= 8'd0;
			len_high_q    <= 8'd0;
			cur_length_q  <= 16'd0;
			bytes_left_q  <= 16'd0;
			attempts_q    <= ifd_pkg::ATTEMPT_LIMIT_RST;
		end else if (accept) begin
			phase_q       <= phase_d;
			cur_channel_q <= cur_channel_d;
			len_high_q    <= len_high_d;
			cur_length_q  <= cur_length_d;
			bytes_left_q  <= bytes_left_d;
			attempts_q    <= attempts_d;
		end
	end

	// Final payload byte always returns the parser to hunting
	assign frame_end = accept && phase_q == ifd_pkg::PH_DATA && bytes_left_q == 16'd1;
	assign hunt_now  = (phase_q == ifd_pkg::PH_HUNT);

	`IFD_ASSERT(a_last_to_hunt, clk, arst_n, frame_end |=> hunt_now, "no hunt after frame end")
	`IFD_ASSERT(a_phase_onehot, clk, arst_n, $onehot(phase_q), "phase code not one-hot")
	`IFD_ASSERT(a_no_push_full, clk, arst_n, push |-> !q_full, "push into full queue")

endmodule

/* sv/ifd_queue.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ifd_queue
// Short register queue of classified results between parser and output.
// ----------------------------------------------------------------------------
module ifd_queue #(
	parameter int DEPTH = 4    // two or more entries
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ifd_pkg::res_t        push_res,
	input  logic                 pop,
	output ifd_pkg::res_t        head,
	output ifd_pkg::q_status_t   status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ifd_pkg::res_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (count_q == CNT_W'(0));
	assign status.full  = (count_q == CNT_W'(DEPTH));

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_res;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	`IFD_ASSERT_ALWAYS(a_count_bound, clk, (count_q <= CNT_W'(DEPTH)), "queue count beyond depth")
	`IFD_ASSERT(a_pop_nonempty, clk, arst_n, pop |-> (count_q != CNT_W'(0)), "pop from empty queue")
	`IFD_ASSERT(a_push_count, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)), "push lost")

endmodule

/* sv/ifd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifd_back
// Output stage: pulls results from the queue, shapes the fields per kind
// and holds them in the output register until transferred.
// ----------------------------------------------------------------------------
module ifd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ifd_pkg::res_t      head,
	input  ifd_pkg::q_status_t status,
	output logic               pop,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [1:0]         kind,
	output logic [7:0]         data,
	output logic [7:0]         chan,
	output logic [15:0]        frame_len,
	output logic               last,
	output logic               sync_lost
);

	logic          out_valid_q;
	ifd_pkg::res_t res_q;
	ifd_pkg::res_t shaped;

	assign pop = !status.empty && (!out_valid_q || !out_stall);

	// Field shaping per result kind
	always_comb begin
		shaped = head;
		case (head.kind)
			ifd_pkg::KIND_BAD_MARK: begin
				shaped.chan      = 8'd0;
				shaped.frame_len = 16'd0;
				shaped.last      = 1'b0;
			end
			ifd_pkg::KIND_BAD_CHAN: begin
				shaped.chan      = head.data;
				shaped.frame_len = 16'd0;
				shaped.last      = 1'b0;
			end
			ifd_pkg::KIND_BAD_LEN: shaped.last = 1'b0;
			default:               shaped.sync_lost = 1'b0;
		endcase
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop) res_q <= shaped;
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign data      = res_q.data;
	assign chan      = res_q.chan;
	assign frame_len = res_q.frame_len;
	assign last      = res_q.last;
	assign sync_lost = res_q.sync_lost;

endmodule

/* sv/interleaved_frame_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_frame_deframer_top
// Deframes interleaved packets from a byte stream: accepts one byte every
// cycle while in_stall is low, hunts for the marker, checks channel and
// length, and emits payload bytes tagged with channel, length and a last
// mark, or an error result with the offending byte and a sync-loss flag.
// Well-formed header bytes give no result. Rate: one byte per cycle sustained
// while the output is not stalled; results pass through the queue into the
// output register. in_stall rises only when the QUEUE_DEPTH-entry result
// queue is full. Configuration writes take effect on the next byte.
// ----------------------------------------------------------------------------
module interleaved_frame_deframer_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [ifd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [ifd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    kind,
	output logic [7:0]                    data,
	output logic [7:0]                    chan,
	output logic [15:0]                   frame_len,
	output logic                          last,
	output logic                          sync_lost
);

	logic               push;
	logic               pop;
	ifd_pkg::res_t      push_res;
	ifd_pkg::res_t      head;
	ifd_pkg::q_status_t status;

	// Parser
	ifd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.rx_byte   (rx_byte),
		.q_full    (status.full),
		.in_stall  (in_stall),
		.push      (push),
		.push_res  (push_res)
	);

	// Result queue
	ifd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	// Output stage
	ifd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.data      (data),
		.chan      (chan),
		.frame_len (frame_len),
		.last      (last),
		.sync_lost (sync_lost)
	);

endmodule

/* bench/interleaved_frame_deframer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_frame_deframer_top_tb
// Self-checking bench for the interleaved frame deframer. Drives received
// bytes over the valid/stall input channel, mostly as well-formed frames with
// random content mixed with noise, bad channels, bad lengths and cut-off
// headers. A built-in parser tracks the expected payload and error records,
// and every record transfer is compared field by field. Several register
// settings are used, limits at both ends among them, with random gaps and
// output stalls throughout.
// ----------------------------------------------------------------------------
module interleaved_frame_deframer_top_tb;

	localparam logic [ifd_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 12;

	// One output record
	typedef struct packed {
		ifd_pkg::kind_t kind;
		logic [7:0]     data;
		logic [7:0]     chan;
		logic [15:0]    frame_len;
		logic           last;
		logic           sync_lost;
	} rec_t;

	// Parser that tracks framing state and the records still owed by the block
	class frame_tracker;
		logic [7:0]      lim_chan;
		logic [15:0]     lim_len;
		logic [15:0]     lim_tries;
		ifd_pkg::phase_t ph;
		logic [7:0]      chan_q;
		logic [7:0]      len_hi_q;
		logic [15:0]     len_q;
		logic [15:0]     remain;
		logic [15:0]     tries;
		rec_t            awaited[$];
		int              errors;

		function new();
			lim_chan  = ifd_pkg::MAX_CHANNEL_RST;
			lim_len   = ifd_pkg::MAX_LENGTH_RST;
			lim_tries = ifd_pkg::ATTEMPT_LIMIT_RST;
			ph        = ifd_pkg::PH_HUNT;
			chan_q    = '0;
			len_hi_q  = '0;
			len_q     = '0;
			remain    = '0;
			tries     = ifd_pkg::ATTEMPT_LIMIT_RST;
			errors    = 0;
		endfunction

		function void write_reg(logic [ifd_pkg::REG_IDX_W-1:0] idx,
				logic [ifd_pkg::CFG_W-1:0] val);
			case (idx)
				ifd_pkg::REG_MAX_CHANNEL: begin
					lim_chan = val[7:0];
				end
				ifd_pkg::REG_MAX_LENGTH: begin
					lim_len = val;
				end
				ifd_pkg::REG_ATTEMPT_LIMIT: begin
					lim_tries = val;
				end
				default: begin
				end
			endcase
		endfunction

		// Failed attempt: back to hunting, flag loss and reload when none left
		function logic give_up();
			logic lost;
			lost = (tries == 16'd0);
			if (lost)
				tries = lim_tries;
			ph = ifd_pkg::PH_HUNT;
			return lost;
		endfunction

		// Accepted byte: advance the parser and queue any record it yields
		function void take_rx_byte(logic [7:0] b);
			rec_t        r;
			logic        hit;
			logic [15:0] len;
			r   = '0;
			hit = 1'b1;
			case (ph)
				ifd_pkg::PH_CHAN: begin
					if (b > lim_chan) begin
						r.sync_lost = give_up();
						r.kind      = ifd_pkg::KIND_BAD_CHAN;
						r.data      = b;
						r.chan      = b;
					end else begin
						chan_q = b;
						ph     = ifd_pkg::PH_LENH;
						hit    = 1'b0;
					end
				end
				ifd_pkg::PH_LENH: begin
					len_hi_q = b;
					ph       = ifd_pkg::PH_LENL;
					hit      = 1'b0;
				end
				ifd_pkg::PH_LENL: begin
					len = {len_hi_q, b};
					if (len == 16'd0 || len > lim_len) begin
						r.sync_lost = give_up();
						r.kind      = ifd_pkg::KIND_BAD_LEN;
						r.data      = b;
						r.chan      = chan_q;
						r.frame_len = len;
					end else begin
						len_q  = len;
						remain = len;
						ph     = ifd_pkg::PH_DATA;
						hit    = 1'b0;
					end
				end
				ifd_pkg::PH_DATA: begin
					remain      = remain - 16'd1;
					r.kind      = ifd_pkg::KIND_PAYLOAD;
					r.data      = b;
					r.chan      = chan_q;
					r.frame_len = len_q;
					if (remain == 16'd0) begin
						r.last = 1'b1;
						tries  = lim_tries;
						ph     = ifd_pkg::PH_HUNT;
					end
				end
				default: begin
					if (tries != 16'd0)
						tries = tries - 16'd1;
					if (b != ifd_pkg::MARKER_BYTE) begin
						r.sync_lost = give_up();
						r.kind      = ifd_pkg::KIND_BAD_MARK;
						r.data      = b;
					end else begin
						ph  = ifd_pkg::PH_CHAN;
						hit = 1'b0;
					end
				end
			endcase
			if (hit)
				awaited.push_back(r);
		endfunction

		function void cmp(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
				errors++;
			end
		endfunction

		// Record transfer: compare against the oldest owed record
		function void match_record(rec_t got);
			rec_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected record, expected none, actual kind %0d data %0d",
					$time, got.kind, got.data);
				errors++;
				return;
			end
			want = awaited.pop_front();
			cmp("kind", 32'(want.kind), 32'(got.kind));
			cmp("data", 32'(want.data), 32'(got.data));
			cmp("chan", 32'(want.chan), 32'(got.chan));
			cmp("frame_len", 32'(want.frame_len), 32'(got.frame_len));
			cmp("last", 32'(want.last), 32'(got.last));
			cmp("sync_lost", 32'(want.sync_lost), 32'(got.sync_lost));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [ifd_pkg::REG_IDX_W-1:0] cfg_index;
	logic [ifd_pkg::CFG_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    rx_byte;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    kind;
	logic [7:0]                    data;
	logic [7:0]                    chan;
	logic [15:0]                   frame_len;
	logic                          last;
	logic                          sync_lost;

	frame_tracker tracker = new();
	bit           quiet;
	int           bytes_sent;

	interleaved_frame_deframer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.data      (data),
		.chan      (chan),
		.frame_len (frame_len),
		.last      (last),
		.sync_lost (sync_lost)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 1);
		if (r < 93)
			return $urandom_range(2, 6);
		return $urandom_range(10, 40);
	endfunction

	// Input side: one byte transfer, with an optional idle gap before it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte  = b;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_rx_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [ifd_pkg::REG_IDX_W-1:0] idx,
			input logic [ifd_pkg::CFG_W-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.write_reg(idx, val);
	endtask

	// Wait for every owed record plus pipeline slack; ends on a falling edge
	task automatic drain();
		in_valid = 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Random traffic: mostly good frames, plus noise and broken headers
	task automatic send_traffic(input int count);
		int          stop_at;
		int          sel;
		int          len;
		int          upper;
		logic [15:0] bad_len;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				quiet = !quiet;
			if (sel < 65) begin
				upper = ($urandom_range(0, 19) == 0) ? 64 : 8;
				if (upper > int'(tracker.lim_len))
					upper = int'(tracker.lim_len);
				len = $urandom_range(1, upper);
				send_byte(ifd_pkg::MARKER_BYTE);
				send_byte(8'($urandom_range(0, int'(tracker.lim_chan))));
				send_byte(len[15:8]);
				send_byte(len[7:0]);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
			end else if (sel < 77 || (sel < 85 && tracker.lim_chan == 8'hFF)) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (sel < 85) begin
				send_byte(ifd_pkg::MARKER_BYTE);
				send_byte(8'($urandom_range(int'(tracker.lim_chan) + 1, 255)));
			end else if (sel < 93) begin
				if (tracker.lim_len == 16'hFFFF || $urandom_range(0, 3) == 0)
					bad_len = '0;
				else
					bad_len = 16'($urandom_range(int'(tracker.lim_len) + 1, 65535));
				send_byte(ifd_pkg::MARKER_BYTE);
				send_byte(8'($urandom_range(0, int'(tracker.lim_chan))));
				send_byte(bad_len[15:8]);
				send_byte(bad_len[7:0]);
			end else begin
				// header cut short; following bytes land in the wrong fields
				send_byte(ifd_pkg::MARKER_BYTE);
				if ($urandom_range(0, 1))
					send_byte(8'($urandom_range(0, int'(tracker.lim_chan))));
				if ($urandom_range(0, 1))
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic run_setting(input logic [ifd_pkg::CFG_W-1:0] ch,
			input logic [ifd_pkg::CFG_W-1:0] ln,
			input logic [ifd_pkg::CFG_W-1:0] tr, input int count);
		drain();
		set_reg(ifd_pkg::REG_MAX_CHANNEL, ch);
		set_reg(ifd_pkg::REG_MAX_LENGTH, ln);
		set_reg(ifd_pkg::REG_ATTEMPT_LIMIT, tr);
		send_traffic(count);
	endtask

	// Output side stall pattern: runs of stall and open cycles
	initial begin
		int run_left;
		out_stall = 1'b0;
		run_left  = 0;
		forever begin
			@(negedge clk);
			if (run_left > 0) begin
				run_left--;
			end else if (out_stall || quiet) begin
				out_stall = 1'b0;
				run_left  = $urandom_range(0, 8);
			end else begin
				out_stall = 1'b1;
				run_left  = pick_stall();
			end
		end
	end

	// Record transfers
	initial begin
		rec_t got;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got.kind      = ifd_pkg::kind_t'(kind);
				got.data      = data;
				got.chan      = chan;
				got.frame_len = frame_len;
				got.last      = last;
				got.sync_lost = sync_lost;
				tracker.match_record(got);
			end
		end
	end

	// Main sequence
	initial begin
		logic [7:0] opening[$];
		opening = '{8'h00, 8'hFF,
			ifd_pkg::MARKER_BYTE, 8'h03,
			ifd_pkg::MARKER_BYTE, 8'h00, 8'h00, 8'h00,
			ifd_pkg::MARKER_BYTE, 8'h02, 8'h06, 8'h41,
			ifd_pkg::MARKER_BYTE, 8'h00, 8'h00, 8'h01, 8'hFF,
			ifd_pkg::MARKER_BYTE, 8'h01, 8'h00, 8'h02, 8'h00, 8'hA5};
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = ifd_pkg::REG_MAX_CHANNEL;
		cfg_data   = '0;
		in_valid   = 1'b0;
		rx_byte    = '0;
		quiet      = 1'b0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset limits: each error kind, boundary length, short frames
		foreach (opening[i])
			send_byte(opening[i]);
		send_traffic(200);

		// Tightest limits: channel 0 only, one-byte frames, one attempt
		run_setting(16'd0, 16'd1, 16'd1, 215);
		// Widest limits
		run_setting(16'd255, 16'd65535, 16'd65535, 215);
		run_setting(16'd7, 16'd20, 16'd3, 215);

		// Upper data bits dropped for the channel limit; zero attempt limit
		drain();
		set_reg(ifd_pkg::REG_MAX_CHANNEL, 16'hAB05);
		set_reg(ifd_pkg::REG_MAX_LENGTH, 16'd300);
		set_reg(ifd_pkg::REG_ATTEMPT_LIMIT, 16'd0);
		set_reg(REG_UNUSED, 16'h1234);
		send_traffic(215);

		repeat (2)
			run_setting(16'($urandom_range(0, 255)), 16'($urandom_range(1, 200)),
				16'($urandom_range(1, 6)), 215);

		drain();
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* interleaved_frame_deframer_top.f */
+incdir+sv
sv/ifd_pkg.sv
sv/ifd_front.sv
sv/ifd_queue.sv
sv/ifd_back.sv
sv/interleaved_frame_deframer_top.sv
bench/interleaved_frame_deframer_top_tb.sv
